// ===== hw/rtl/mcq_pkg.sv =====
// ----------------------------------------------------------------------------
// mcq_pkg
// Palette tables, distance function and shared types of the cell quantizer.
// ----------------------------------------------------------------------------
package mcq_pkg;

	localparam int PAL_SIZE     = 16;
	localparam int CELL_PIXELS  = 32;
	localparam int NIBBLE_SCALE = 17;

	localparam logic [7:0] PAL_R [PAL_SIZE] = '{
		8'd0, 8'd255, 8'd136, 8'd103, 8'd139, 8'd85, 8'd64, 8'd191,
		8'd139, 8'd87, 8'd184, 8'd80, 8'd120, 8'd148, 8'd120, 8'd159};
	localparam logic [7:0] PAL_G [PAL_SIZE] = '{
		8'd0, 8'd255, 8'd57, 8'd182, 8'd63, 8'd160, 8'd49, 8'd206,
		8'd84, 8'd66, 8'd105, 8'd80, 8'd120, 8'd224, 8'd105, 8'd159};
	localparam logic [7:0] PAL_B [PAL_SIZE] = '{
		8'd0, 8'd255, 8'd50, 8'd189, 8'd150, 8'd73, 8'd141, 8'd114,
		8'd41, 8'd0, 8'd98, 8'd80, 8'd120, 8'd137, 8'd196, 8'd159};

	localparam logic [7:0] PREV_CLEAR = 8'hFF;

	typedef logic [17:0] dist_t;

	// classified pixel from intake to cell engine
	typedef struct packed {
		logic        valid;
		logic        last;
		logic [4:0]  slot;
		logic [3:0]  idx;
		logic [23:0] rgb;
		logic [9:0]  cell_id;
	} pix_t;

	// finished cell from engine to top
	typedef struct packed {
		logic        done;
		logic [9:0]  cell_id;
		logic [63:0] bits;
		logic [7:0]  screen;
		logic [3:0]  color;
	} cell_res_t;

	function automatic logic [7:0] expand_nibble(input logic [3:0] nib);
		return 8'({4'b0, nib} * 8'(NIBBLE_SCALE));
	endfunction

	function automatic dist_t sq_dist(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [3:0] c);
		logic signed [9:0]  dr;
		logic signed [9:0]  dg;
		logic signed [9:0]  db;
		logic signed [19:0] sr;
		logic signed [19:0] sg;
		logic signed [19:0] sb;
		dr = $signed({2'b0, r}) - $signed({2'b0, PAL_R[c]});
		dg = $signed({2'b0, g}) - $signed({2'b0, PAL_G[c]});
		db = $signed({2'b0, b}) - $signed({2'b0, PAL_B[c]});
		sr = dr * dr;
		sg = dg * dg;
		sb = db * db;
		return dist_t'(sr + sg + sb);
	endfunction

endpackage

// ===== hw/rtl/mcq_classify.sv =====
// ----------------------------------------------------------------------------
// mcq_classify
// Pixel intake: palette distances in one stage, argmin tree, pixel counter.
// ----------------------------------------------------------------------------
module mcq_classify (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [9:0]        in_cell,
	input  logic [7:0]        in_red,
	input  logic [7:0]        in_green,
	input  logic [7:0]        in_blue,
	output mcq_pkg::pix_t     pix,
	output logic              busy
);
	import mcq_pkg::*;

	dist_t       dist_s1 [PAL_SIZE];
	logic [23:0] rgb_s1;
	logic [9:0]  cell_s1;
	logic [4:0]  slot_s1;
	logic        last_s1;
	logic        valid_s1;
	logic [4:0]  count_q;

	dist_t      d_l1 [8];
	logic [3:0] i_l1 [8];
	dist_t      d_l2 [4];
	logic [3:0] i_l2 [4];
	dist_t      d_l3 [2];
	logic [3:0] i_l3 [2];
	logic [3:0] best_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			count_q  <= '0;
		end else begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				last_s1 <= (count_q == 5'(CELL_PIXELS - 1));
				count_q <= count_q + 5'd1;
			end else begin
				last_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			for (int c = 0; c < PAL_SIZE; c++) begin
				dist_s1[c] <= sq_dist(expand_nibble(in_red[7:4]),
					expand_nibble(in_green[7:4]), expand_nibble(in_blue[7:4]), 4'(c));
			end
			rgb_s1  <= {in_red, in_green, in_blue};
			cell_s1 <= in_cell;
			slot_s1 <= count_q;
		end
	end

	// lower index stays on the left, so ties keep it
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (dist_s1[2*i+1] < dist_s1[2*i]) begin
				d_l1[i] = dist_s1[2*i+1];
				i_l1[i] = 4'(2*i+1);
			end else begin
				d_l1[i] = dist_s1[2*i];
				i_l1[i] = 4'(2*i);
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (d_l1[2*i+1] < d_l1[2*i]) begin
				d_l2[i] = d_l1[2*i+1];
				i_l2[i] = i_l1[2*i+1];
			end else begin
				d_l2[i] = d_l1[2*i];
				i_l2[i] = i_l1[2*i];
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (d_l2[2*i+1] < d_l2[2*i]) begin
				d_l3[i] = d_l2[2*i+1];
				i_l3[i] = i_l2[2*i+1];
			end else begin
				d_l3[i] = d_l2[2*i];
				i_l3[i] = i_l2[2*i];
			end
		end
		best_idx = (d_l3[1] < d_l3[0]) ? i_l3[1] : i_l3[0];
	end

	assign pix.valid   = valid_s1;
	assign pix.last    = last_s1;
	assign pix.slot    = slot_s1;
	assign pix.idx     = best_idx;
	assign pix.rgb     = rgb_s1;
	assign pix.cell_id = cell_s1;
	assign busy        = valid_s1 && last_s1;

endmodule

// ===== hw/rtl/mcq_cell_engine.sv =====
// ----------------------------------------------------------------------------
// mcq_cell_engine
// Pixel memory, histogram, top-three color selection and bitmap encoding.
// ----------------------------------------------------------------------------
module mcq_cell_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  mcq_pkg::pix_t      pix,
	input  logic               res_ack,
	output mcq_pkg::cell_res_t res,
	output logic               idle
);
	import mcq_pkg::*;

	typedef enum logic [2:0] {
		COLLECT,
		SELECT,
		ENC_RD,
		ENC_CHK,
		ENC_DIST,
		DONE
	} state_t;

	state_t      state_q;
	logic [27:0] pix_mem [CELL_PIXELS];
	logic [27:0] rd_q;
	logic [5:0]  hist_q [PAL_SIZE];
	logic [3:0]  sel_q;
	logic [3:0]  c1_q, c2_q, c3_q;
	logic [5:0]  f1_q, f2_q, f3_q;
	logic [4:0]  p_q;
	logic [1:0]  opt_q;
	dist_t       best_q;
	logic [1:0]  code_q;
	logic [63:0] bits_q;
	logic [9:0]  cell_q;

	logic [5:0]  h;
	logic [3:0]  rd_idx;
	logic [3:0]  opt_c;
	dist_t       d;
	logic        take;
	logic [5:0]  pos;

	assign h      = hist_q[sel_q];
	assign rd_idx = rd_q[27:24];
	assign pos    = {p_q[4:2], ~p_q[1:0], 1'b0};
	assign d      = sq_dist(rd_q[23:16], rd_q[15:8], rd_q[7:0], opt_c);
	assign take   = (opt_q == 2'd0) || (d < best_q);

	always_comb begin
		case (opt_q)
			2'd1:    opt_c = c1_q;
			2'd2:    opt_c = c2_q;
			2'd3:    opt_c = c3_q;
			default: opt_c = 4'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pix.valid) begin
			pix_mem[pix.slot] <= {pix.idx, pix.rgb};
		end
		if (state_q == ENC_RD) begin
			rd_q <= pix_mem[p_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= COLLECT;
			for (int c = 0; c < PAL_SIZE; c++) hist_q[c] <= '0;
			sel_q  <= 4'd1;
			c1_q   <= '0;
			c2_q   <= '0;
			c3_q   <= '0;
			f1_q   <= '0;
			f2_q   <= '0;
			f3_q   <= '0;
			p_q    <= '0;
			opt_q  <= '0;
			best_q <= '0;
			code_q <= '0;
			bits_q <= '0;
			cell_q <= '0;
		end else begin
			unique case (state_q)
				COLLECT: begin
					if (pix.valid) begin
						hist_q[pix.idx] <= hist_q[pix.idx] + 6'd1;
						if (pix.last) begin
							cell_q  <= pix.cell_id;
							sel_q   <= 4'd1;
							c1_q    <= '0;
							c2_q    <= '0;
							c3_q    <= '0;
							f1_q    <= '0;
							f2_q    <= '0;
							f3_q    <= '0;
							state_q <= SELECT;
						end
					end
				end
				SELECT: begin
					if (h > f1_q) begin
						c3_q <= c2_q;
						f3_q <= f2_q;
						c2_q <= c1_q;
						f2_q <= f1_q;
						c1_q <= sel_q;
						f1_q <= h;
					end else if (h > f2_q) begin
						c3_q <= c2_q;
						f3_q <= f2_q;
						c2_q <= sel_q;
						f2_q <= h;
					end else if (h > f3_q) begin
						c3_q <= sel_q;
						f3_q <= h;
					end
					if (sel_q == 4'(PAL_SIZE - 1)) begin
						for (int c = 0; c < PAL_SIZE; c++) hist_q[c] <= '0;
						p_q     <= '0;
						state_q <= ENC_RD;
					end else begin
						sel_q <= sel_q + 4'd1;
					end
				end
				ENC_RD: begin
					state_q <= ENC_CHK;
				end
				ENC_CHK: begin
					if (rd_idx == c1_q || rd_idx == c2_q || rd_idx == c3_q) begin
						if (rd_idx == c1_q) bits_q[pos +: 2] <= 2'd1;
						else if (rd_idx == c2_q) bits_q[pos +: 2] <= 2'd2;
						else bits_q[pos +: 2] <= 2'd3;
						if (p_q == 5'(CELL_PIXELS - 1)) begin
							state_q <= DONE;
						end else begin
							p_q     <= p_q + 5'd1;
							state_q <= ENC_RD;
						end
					end else begin
						opt_q   <= 2'd0;
						state_q <= ENC_DIST;
					end
				end
				ENC_DIST: begin
					if (take) begin
						best_q <= d;
						code_q <= opt_q;
					end
					if (opt_q == 2'd3) begin
						bits_q[pos +: 2] <= take ? opt_q : code_q;
						if (p_q == 5'(CELL_PIXELS - 1)) begin
							state_q <= DONE;
						end else begin
							p_q     <= p_q + 5'd1;
							state_q <= ENC_RD;
						end
					end else begin
						opt_q <= opt_q + 2'd1;
					end
				end
				DONE: begin
					if (res_ack) begin
						state_q <= COLLECT;
					end
				end
				default: begin
					state_q <= COLLECT;
				end
			endcase
		end
	end

	assign res.done    = (state_q == DONE);
	assign res.cell_id = cell_q;
	assign res.bits    = bits_q;
	assign res.screen  = {c1_q, c2_q};
	assign res.color   = c3_q;
	assign idle        = (state_q == COLLECT);

endmodule

// ===== hw/rtl/multicolor_cell_quantizer.sv =====
// ----------------------------------------------------------------------------
// multicolor_cell_quantizer
// Multicolor cell palette quantizer with per-cell change detection.
//
// The slave stream carries one pixel per beat, 32 beats per 4x8 cell in
// row-major order; the cell index of the last beat names the cell. Each
// pixel is classified against a 16-color palette as it arrives, one beat a
// cycle. After the 32nd beat the input is held off while the cell engine
// scans the histogram, encodes the 32 pixels from the pixel memory (a
// direct code for an exact color match, else a distance search) and, for a
// cell in range, compares the result against the previous-cell memory.
// A changed cell leaves as one master beat held in an output register; the
// next cell is accepted while it waits, and processing stalls at the compare
// only if a second changed result is ready before the first is taken.
// After reset a clearing pass writes every previous-cell entry with the
// input held off. Cells at or above CELL_COUNT are encoded but give no beat
// and leave the memory untouched.
// ----------------------------------------------------------------------------
module multicolor_cell_quantizer #(
	parameter int CELL_COUNT = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cell_index[9:0], red, green, blue, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata    // out_cell[9:0], row_bits0..7, screen_byte,
	                               // color_byte[3:0], zero pad
);
	import mcq_pkg::*;

	localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int PW = 80;

	typedef enum logic [1:0] {
		CLEAR,
		RUN,
		PREV_CMP
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  clr_cnt_q;
	logic [PW-1:0]  prev_mem [CELL_COUNT];
	logic [PW-1:0]  prev_q;
	logic [87:0]    out_q;
	logic           out_valid_q;

	pix_t           pix;
	cell_res_t      res;
	logic           clf_busy;
	logic           eng_idle;
	logic           res_ack;
	logic           in_range;
	logic [AW-1:0]  addr;
	logic [PW-1:0]  cur;
	logic           changed;
	logic           space;
	logic           load;
	logic           s_acc;

	assign s_tready = (state_q != CLEAR) && eng_idle && !clf_busy;
	assign s_acc    = s_tvalid && s_tready;

	mcq_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_acc),
		.in_cell  (s_tdata[9:0]),
		.in_red   (s_tdata[17:10]),
		.in_green (s_tdata[25:18]),
		.in_blue  (s_tdata[33:26]),
		.pix      (pix),
		.busy     (clf_busy)
	);

	mcq_cell_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix),
		.res_ack (res_ack),
		.res     (res),
		.idle    (eng_idle)
	);

	assign in_range = {3'b0, res.cell_id} < 13'(CELL_COUNT);
	assign addr     = AW'(res.cell_id);
	assign cur      = {res.bits, res.screen, 4'b0, res.color};
	assign changed  = (prev_q != cur);
	assign space    = !out_valid_q || m_tready;
	assign load     = (state_q == PREV_CMP) && changed && space;
	assign res_ack  = ((state_q == RUN) && res.done && !in_range)
	                || ((state_q == PREV_CMP) && (!changed || space));

	always_ff @(posedge clk) begin
		if (state_q == CLEAR) begin
			prev_mem[clr_cnt_q] <= {64'b0, PREV_CLEAR, PREV_CLEAR};
		end else if (load) begin
			prev_mem[addr] <= cur;
		end
		if (state_q == RUN && res.done && in_range) begin
			prev_q <= prev_mem[addr];
		end
		if (load) begin
			out_q <= {2'b0, res.color, res.screen, res.bits, res.cell_id};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					if (clr_cnt_q == AW'(CELL_COUNT - 1)) begin
						state_q <= RUN;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				RUN: begin
					if (res.done && in_range) begin
						state_q <= PREV_CMP;
					end
				end
				PREV_CMP: begin
					if (res_ack) begin
						state_q <= RUN;
					end
				end
				default: begin
					state_q <= RUN;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// ===== verif/cell_quantizer_checker.sv =====
// ----------------------------------------------------------------------------
// cell_quantizer_checker
// Watches both streams of the cell quantizer, predicts each changed cell from
// the accepted pixel beats and compares every output beat field by field.
// ----------------------------------------------------------------------------
module cell_quantizer_checker #(
	parameter int CELL_COUNT = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	output int          fail_count,
	output int          pending
);
	import mcq_pkg::*;

	typedef struct packed {
		logic [9:0]  cell_id;
		logic [63:0] rows;
		logic [7:0]  screen;
		logic [3:0]  color;
	} cell_beat_t;

	logic [23:0] pix_rgb [CELL_PIXELS];
	logic [3:0]  pix_idx [CELL_PIXELS];
	int          hist [PAL_SIZE];
	int          slot_cnt;
	logic [63:0] last_rows [CELL_COUNT];
	logic [7:0]  last_screen [CELL_COUNT];
	logic [7:0]  last_color [CELL_COUNT];
	cell_beat_t  changed_cells [$];

	function automatic int color_dist(int r, int g, int b, int c);
		int dr;
		int dg;
		int db;
		dr = r - int'(PAL_R[c]);
		dg = g - int'(PAL_G[c]);
		db = b - int'(PAL_B[c]);
		return dr * dr + dg * dg + db * db;
	endfunction

	function automatic logic [3:0] nearest_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int bd;
		int d;
		int best;
		best = 0;
		bd = color_dist(r[7:4] * 17, g[7:4] * 17, b[7:4] * 17, 0);
		for (int c = 1; c < PAL_SIZE; c++) begin
			d = color_dist(r[7:4] * 17, g[7:4] * 17, b[7:4] * 17, c);
			if (d < bd) begin
				bd = d;
				best = c;
			end
		end
		return 4'(best);
	endfunction

	task automatic encode_cell(logic [9:0] cell_id);
		int c1, c2, c3, f1, f2, f3, h, code, bd, d;
		int opts [4];
		logic [7:0] rows [8];
		logic [63:0] bits;
		cell_beat_t res;
		c1 = 0; c2 = 0; c3 = 0; f1 = 0; f2 = 0; f3 = 0;
		for (int c = 1; c < PAL_SIZE; c++) begin
			h = hist[c];
			if (h > f1) begin
				c3 = c2; f3 = f2; c2 = c1; f2 = f1; c1 = c; f1 = h;
			end else if (h > f2) begin
				c3 = c2; f3 = f2; c2 = c; f2 = h;
			end else if (h > f3) begin
				c3 = c; f3 = h;
			end
		end
		for (int c = 0; c < PAL_SIZE; c++) hist[c] = 0;
		opts = '{0, c1, c2, c3};
		for (int p = 0; p < 8; p++) rows[p] = '0;
		for (int p = 0; p < CELL_PIXELS; p++) begin
			if (pix_idx[p] == c1) code = 1;
			else if (pix_idx[p] == c2) code = 2;
			else if (pix_idx[p] == c3) code = 3;
			else begin
				code = 0;
				bd = color_dist(pix_rgb[p][23:16], pix_rgb[p][15:8], pix_rgb[p][7:0], 0);
				for (int k = 1; k < 4; k++) begin
					d = color_dist(pix_rgb[p][23:16], pix_rgb[p][15:8], pix_rgb[p][7:0],
						opts[k]);
					if (d < bd) begin
						bd = d;
						code = k;
					end
				end
			end
			rows[p / 4] = {rows[p / 4][5:0], 2'(code)};
		end
		for (int p = 0; p < 8; p++) bits[8 * p +: 8] = rows[p];
		if (cell_id < CELL_COUNT) begin
			if (last_rows[cell_id] != bits || last_screen[cell_id] != 8'({4'(c1), 4'(c2)})
					|| last_color[cell_id] != 8'(c3)) begin
				last_rows[cell_id] = bits;
				last_screen[cell_id] = {4'(c1), 4'(c2)};
				last_color[cell_id] = 8'(c3);
				res.cell_id = cell_id;
				res.rows = bits;
				res.screen = {4'(c1), 4'(c2)};
				res.color = 4'(c3);
				changed_cells.push_back(res);
			end
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		slot_cnt = 0;
		for (int c = 0; c < PAL_SIZE; c++) hist[c] = 0;
		for (int i = 0; i < CELL_COUNT; i++) begin
			last_rows[i] = '0;
			last_screen[i] = PREV_CLEAR;
			last_color[i] = PREV_CLEAR;
		end
	end

	always @(posedge clk) begin
		cell_beat_t want;
		cell_beat_t got;
		logic [3:0] ix;
		if (arst_n && s_tvalid && s_tready) begin
			ix = nearest_color(s_tdata[17:10], s_tdata[25:18], s_tdata[33:26]);
			pix_rgb[slot_cnt] = {s_tdata[17:10], s_tdata[25:18], s_tdata[33:26]};
			pix_idx[slot_cnt] = ix;
			hist[ix] = (hist[ix] + 1) % 64;
			if (slot_cnt == CELL_PIXELS - 1) begin
				slot_cnt = 0;
				encode_cell(s_tdata[9:0]);
			end else begin
				slot_cnt++;
			end
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.cell_id = m_tdata[9:0];
			got.rows = m_tdata[73:10];
			got.screen = m_tdata[81:74];
			got.color = m_tdata[85:82];
			if (changed_cells.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("unexpected output beat %h", m_tdata);
			end else begin
				want = changed_cells.pop_front();
				if (want != got) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch cell %0d/%0d rows %h/%h screen %h/%h color %h/%h",
							want.cell_id, got.cell_id, want.rows, got.rows, want.screen,
							got.screen, want.color, got.color);
				end
			end
		end
		pending = changed_cells.size();
	end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives pixel cells into the cell quantizer with random gaps and output
// stalls; the checker predicts changed cells and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CELLS = 1000;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // cell_index[9:0], red, green, blue, zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // out_cell[9:0], row_bits0..7, screen_byte, color_byte, pad
	int          fail_count;
	int          pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          quiet_cycles;

	multicolor_cell_quantizer #(.CELL_COUNT(CELLS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	cell_quantizer_checker #(.CELL_COUNT(CELLS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[multicolor_cell_quantizer] ERROR");
			$finish;
		end
	end

	task automatic send_pixel(logic [9:0] cell_id, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, b, g, r, cell_id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// mode 0 random, 1 few colors, 2 solid palette color, 3 grayscale
	task automatic send_cell(logic [9:0] cell_id, int mode);
		int pick [3];
		int c;
		for (int k = 0; k < 3; k++) pick[k] = $urandom_range(15);
		for (int p = 0; p < 32; p++) begin
			case (mode)
				0: send_pixel(cell_id, 8'($urandom), 8'($urandom), 8'($urandom));
				1: begin
					c = pick[$urandom_range(2)];
					send_pixel(cell_id, mcq_pkg::PAL_R[c] ^ 8'($urandom_range(7)),
						mcq_pkg::PAL_G[c] ^ 8'($urandom_range(7)),
						mcq_pkg::PAL_B[c] ^ 8'($urandom_range(7)));
				end
				2: send_pixel(cell_id, mcq_pkg::PAL_R[pick[0]], mcq_pkg::PAL_G[pick[0]],
					mcq_pkg::PAL_B[pick[0]]);
				default: begin
					c = $urandom_range(255);
					send_pixel(cell_id, 8'(c), 8'(c), 8'(c));
				end
			endcase
		end
	endtask

	task automatic send_phase(int cells);
		logic [9:0] cell_id;
		for (int i = 0; i < cells; i++) begin
			cell_id = ($urandom_range(9) == 0) ? 10'($urandom_range(1023, 1000))
				: 10'($urandom_range(7));
			if ($urandom_range(3) == 0) send_cell(cell_id, 0);
			else send_cell(cell_id, $urandom_range(3, 1));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// directed: black cell at top index, white cell at 0, repeat (no change), out-of-range cell
		for (int p = 0; p < 32; p++) send_pixel(10'd999, 8'h00, 8'h00, 8'h00);
		for (int p = 0; p < 32; p++) send_pixel(10'd0, 8'hFF, 8'hFF, 8'hFF);
		for (int p = 0; p < 32; p++) send_pixel(10'd0, 8'hFF, 8'hFF, 8'hFF);
		for (int p = 0; p < 32; p++) send_pixel(10'd1023, 8'hFF, 8'h00, 8'hFF);
		send_idle_pct = 33;
		recv_idle_pct = 86;
		send_phase(9);
		send_idle_pct = 86;
		recv_idle_pct = 33;
		send_phase(9);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_phase(8);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("[multicolor_cell_quantizer] OK");
		end else begin
			$display("[multicolor_cell_quantizer] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mcq_pkg.sv
hw/rtl/mcq_classify.sv
hw/rtl/mcq_cell_engine.sv
hw/rtl/multicolor_cell_quantizer.sv
verif/cell_quantizer_checker.sv
verif/testbench.sv
